// File: sv/sptb_pkg.sv
// ============================================================================
// sptb_pkg
// Shared types and constants for the pausable scaled time base.
// ============================================================================
package sptb_pkg;

    // Width of the raw hardware counter; readings are taken modulo 2^COUNT_WIDTH.
    localparam int COUNT_WIDTH = 64;

    localparam int TIME_W  = 64;
    localparam int SPEED_W = 32;
    localparam int FRAC_W  = 16;
    localparam int HALF_W  = TIME_W / 2;
    localparam int PROD_W  = HALF_W + SPEED_W;

    localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1) << FRAC_W;

    localparam int IN_TDATA_W  = ((TIME_W + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = TIME_W;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_PAUSE = 1'b1;

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic query;
        logic pause_on;
    } sptb_ctl_t;

endpackage

// File: sv/sptb_delta.sv
// ============================================================================
// sptb_delta
// Input register, counter difference and magnitude/sign split.
// ============================================================================
module sptb_delta
    import sptb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  sptb_ctl_t            in_ctl,
    input  logic [TIME_W-1:0]    in_raw,
    output sptb_ctl_t            out_ctl,
    output logic [TIME_W-1:0]    out_mag,
    output logic                 out_neg
);

    sptb_ctl_t                 s1_ctl_reg;
    logic [COUNT_WIDTH-1:0]    s1_raw_reg;
    sptb_ctl_t                 s2_ctl_reg;
    logic signed [TIME_W-1:0]  s2_delta_reg;
    sptb_ctl_t                 s3_ctl_reg;
    logic [TIME_W-1:0]         s3_mag_reg;
    logic                      s3_neg_reg;
    logic [COUNT_WIDTH-1:0]    prev_raw_reg;

    logic signed [COUNT_WIDTH-1:0] diff;
    logic signed [TIME_W-1:0]      delta_next;

    // The difference is read as a signed COUNT_WIDTH-bit number, then sign-extended.
    assign diff       = signed'(s1_raw_reg - prev_raw_reg);
    assign delta_next = diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg   <= '0;
            s2_ctl_reg   <= '0;
            s3_ctl_reg   <= '0;
            prev_raw_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            if (s1_ctl_reg.valid && s1_ctl_reg.query)
            begin
                prev_raw_reg <= s1_raw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_raw_reg   <= in_raw[COUNT_WIDTH-1:0];
            s2_delta_reg <= delta_next;
            s3_neg_reg   <= s2_delta_reg[TIME_W-1];
            s3_mag_reg   <= s2_delta_reg[TIME_W-1] ? TIME_W'(-s2_delta_reg)
                                                   : TIME_W'(s2_delta_reg);
        end
    end

    assign out_ctl = s3_ctl_reg;
    assign out_mag = s3_mag_reg;
    assign out_neg = s3_neg_reg;

endmodule

// File: sv/sptb_scale.sv
// ============================================================================
// sptb_scale
// Q16.16 scaling of the counter difference: split multiply, recombine,
// sign restore and lower clamp.
// ============================================================================
module sptb_scale
    import sptb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [SPEED_W-1:0]   speed,
    input  sptb_ctl_t            in_ctl,
    input  logic [TIME_W-1:0]    in_mag,
    input  logic                 in_neg,
    output sptb_ctl_t            out_ctl,
    output logic [TIME_W-1:0]    out_adv
);

    sptb_ctl_t           s4_ctl_reg;
    logic [PROD_W-1:0]   s4_plo_reg;
    logic [PROD_W-1:0]   s4_phi_reg;
    logic [TIME_W-1:0]   s4_mag_reg;
    logic                s4_neg_reg;
    sptb_ctl_t           s5_ctl_reg;
    logic [TIME_W-1:0]   s5_q_reg;
    logic                s5_neg_reg;
    sptb_ctl_t           s6_ctl_reg;
    logic [TIME_W-1:0]   s6_adv_reg;

    logic                unity;
    logic [TIME_W-1:0]   q_next;
    logic [TIME_W-1:0]   signed_q;
    logic [TIME_W-1:0]   adv_next;

    assign unity = (speed == SPEED_ONE);

    // At normal speed the magnitude passes unscaled, so the sign restore yields the raw delta.
    assign q_next = unity ? s4_mag_reg
                          : (TIME_W'(s4_phi_reg) << FRAC_W) + TIME_W'(s4_plo_reg >> FRAC_W);

    assign signed_q = s5_neg_reg ? (~s5_q_reg + TIME_W'(1)) : s5_q_reg;
    assign adv_next = (!unity && (signed_q == '0 || signed_q[TIME_W-1])) ? TIME_W'(1)
                                                                         : signed_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else if (en)
        begin
            s4_ctl_reg <= in_ctl;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_plo_reg <= PROD_W'(in_mag[HALF_W-1:0]) * PROD_W'(speed);
            s4_phi_reg <= PROD_W'(in_mag[TIME_W-1:HALF_W]) * PROD_W'(speed);
            s4_mag_reg <= in_mag;
            s4_neg_reg <= in_neg;
            s5_q_reg   <= q_next;
            s5_neg_reg <= s4_neg_reg;
            s6_adv_reg <= adv_next;
        end
    end

    assign out_ctl = s6_ctl_reg;
    assign out_adv = s6_adv_reg;

    // Off normal speed, a running advance is always a positive value.
    a_adv_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (s6_ctl_reg.valid && s6_ctl_reg.query && !unity)
            |-> (!s6_adv_reg[TIME_W-1] && s6_adv_reg != '0))
        else $error("scaled advance is not positive");

    // At normal speed the recombined value is the magnitude itself.
    a_unity_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (en && unity && $stable(speed)) |=> (s5_q_reg == $past(s4_mag_reg)))
        else $error("unscaled path altered the magnitude");

endmodule

// File: sv/sptb_accum.sv
// ============================================================================
// sptb_accum
// Virtual time state, pause bookkeeping and the result register.
// ============================================================================
module sptb_accum
    import sptb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  sptb_ctl_t                 in_ctl,
    input  logic [TIME_W-1:0]         in_adv,
    output logic                      out_valid,
    output logic [OUT_TDATA_W-1:0]    out_time
);

    // run_reg holds virtual time minus paused total; hold_reg holds pause start
    // minus paused total, which is both the paused answer and the value run_reg
    // takes back on resume.
    logic [TIME_W-1:0]   run_reg;
    logic [TIME_W-1:0]   hold_reg;
    logic                paused_reg;
    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_time_reg;

    logic [TIME_W-1:0]   run_sum;
    logic                do_query;
    logic                do_pause;
    logic                do_resume;

    assign run_sum   = run_reg + in_adv;
    assign do_query  = en && in_ctl.valid && in_ctl.query;
    assign do_pause  = en && in_ctl.valid && !in_ctl.query && in_ctl.pause_on && !paused_reg;
    assign do_resume = en && in_ctl.valid && !in_ctl.query && !in_ctl.pause_on && paused_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            hold_reg      <= '0;
            paused_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                out_valid_reg <= in_ctl.valid && in_ctl.query;
            end
            if (do_query && !paused_reg)
            begin
                run_reg <= run_sum;
            end
            if (do_pause)
            begin
                hold_reg   <= run_reg;
                paused_reg <= 1'b1;
            end
            if (do_resume)
            begin
                run_reg    <= hold_reg;
                paused_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_query)
        begin
            out_time_reg <= paused_reg ? hold_reg : run_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_time  = out_time_reg;

    a_pause_entry: assert property (@(posedge clk) disable iff (!rst_n)
        do_pause |=> (paused_reg && hold_reg == $past(run_reg)))
        else $error("pause entry did not capture the running time");

    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        do_resume |=> (!paused_reg && run_reg == $past(hold_reg)))
        else $error("resume did not restore the held time");

    a_no_result_for_pause: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !(in_ctl.valid && in_ctl.query)) |=> !out_valid_reg)
        else $error("result produced without a query");

    a_paused_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (do_query && paused_reg) |=> (out_time_reg == hold_reg))
        else $error("paused query answered with a moving time");

endmodule

// File: sv/pausable_scaled_time_base_core.sv
// ============================================================================
// pausable_scaled_time_base_core
// Virtual time base over a raw counter, with pause and Q16.16 speed scaling.
// ============================================================================
//
//  channel  | direction | handshake             | contents
//  ---------+-----------+-----------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready   | tuser: req_type; tdata: raw_count,
//           |           |                       | pause_on
//  m_*      | out       | m_tvalid / m_tready   | tdata: virtual_time
//  cfg_*    | in        | cfg_valid / cfg_ready | cfg_data: play_speed
//
// One transfer is accepted per cycle unless the pipeline holds; a query's result
// reaches m_tvalid through the seven register stages from the input register,
// loaded at the accepting edge, to the result register (two 32x32 multipliers).
// The whole pipeline holds while the result register is full and m_tready is low.
// Reset clears all time state and sets the speed to 1.0; no clearing pass.
// The configuration channel is always ready.
// ============================================================================
module pausable_scaled_time_base_core
    import sptb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_W-1:0]     s_tdata,   // [63:0] raw_count, [64] pause_on, rest zero
    input  logic                      s_tuser,   // [0] req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_W-1:0]    m_tdata,   // [63:0] virtual_time
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SPEED_W-1:0]        cfg_data
);

    logic [SPEED_W-1:0]  speed_reg;
    logic                en;
    sptb_ctl_t           in_ctl;
    sptb_ctl_t           mag_ctl;
    sptb_ctl_t           adv_ctl;
    logic [TIME_W-1:0]   mag;
    logic                neg;
    logic [TIME_W-1:0]   adv;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign in_ctl.valid    = s_tvalid;
    assign in_ctl.query    = (s_tuser == REQ_QUERY);
    assign in_ctl.pause_on = s_tdata[TIME_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            speed_reg <= cfg_data;
        end
    end

    sptb_delta u_delta (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (in_ctl),
        .in_raw  (s_tdata[TIME_W-1:0]),
        .out_ctl (mag_ctl),
        .out_mag (mag),
        .out_neg (neg)
    );

    sptb_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .speed   (speed_reg),
        .in_ctl  (mag_ctl),
        .in_mag  (mag),
        .in_neg  (neg),
        .out_ctl (adv_ctl),
        .out_adv (adv)
    );

    sptb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (adv_ctl),
        .in_adv    (adv),
        .out_valid (m_tvalid),
        .out_time  (m_tdata)
    );

endmodule

// File: bench/tb_pausable_scaled_time_base_core.sv
// ============================================================================
// tb_pausable_scaled_time_base_core
// Self-checking bench for the pausable, speed-scaled virtual time base.
//
// A short table of directed requests covers reset state, backward and extreme
// counter jumps, redundant pause requests, and zero, full-scale, half and
// double speed. Random phases then follow, each with its own speed. Every
// query result is compared with a local prediction of the time base. Both
// stream sides stall in random bursts, except in the third and the last phase.
// ============================================================================
module tb_pausable_scaled_time_base_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sptb_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;    // seven-stage pipeline plus margin
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 105;

    typedef enum logic {ROW_ITEM, ROW_RATE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               req;
        logic               pon;
        logic [63:0]        raw;
        logic [SPEED_W-1:0] rate;
        logic               typed;
        logic [63:0]        vtime;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [63:0] raw_count, [64] pause_on, rest zero
    logic                   s_tuser;    // [0] req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [63:0] virtual_time
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [SPEED_W-1:0]     cfg_data;

    // Predicted time base state.
    logic [SPEED_W-1:0]     rate_q16;
    logic [COUNT_WIDTH-1:0] last_raw;
    logic [63:0]            run_time;
    logic [63:0]            pause_mark;
    logic [63:0]            pause_sum;
    logic                   held;

    logic [63:0]            vtime_due[$];
    int                     errors = 0;
    int unsigned            idle_odds = 0;
    int unsigned            ready_hold = 0;

    plan_row_t              plan [28];

    pausable_scaled_time_base_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Signed counter step times the Q16.16 rate, truncated toward zero, at least 1.
    function automatic logic [63:0] scaled_step(input logic [63:0] delta,
                                                input logic [SPEED_W-1:0] rate);
        logic        neg;
        logic [63:0] mag;
        logic [95:0] prod;
        logic [63:0] q;
        neg  = delta[63];
        mag  = neg ? -delta : delta;
        prod = 96'(mag) * 96'(rate);
        q    = prod[79:16];
        if (neg)
        begin
            q = -q;
        end
        if (q == 64'd0 || q[63])
        begin
            q = 64'd1;
        end
        return q;
    endfunction

    task automatic apply_request(input logic req, input logic [63:0] raw, input logic pon,
                                 output logic gives, output logic [63:0] vtime);
        logic [COUNT_WIDTH-1:0] step;
        logic [63:0]            delta;
        gives = 1'b0;
        vtime = '0;
        if (req == REQ_PAUSE)
        begin
            if (pon && !held)
            begin
                pause_mark = run_time;
                held       = 1'b1;
            end
            else if (!pon && held)
            begin
                pause_sum = pause_sum + (run_time - pause_mark);
                held      = 1'b0;
            end
        end
        else
        begin
            step     = raw[COUNT_WIDTH-1:0] - last_raw;
            delta    = 64'($signed(step));
            last_raw = raw[COUNT_WIDTH-1:0];
            gives    = 1'b1;
            if (!held)
            begin
                run_time = run_time +
                           ((rate_q16 == SPEED_ONE) ? delta : scaled_step(delta, rate_q16));
                vtime = run_time - pause_sum;
            end
            else
            begin
                vtime = pause_mark - pause_sum;
            end
        end
    endtask

    task automatic send_request(input logic req, input logic [63:0] raw, input logic pon,
                                input logic typed, input logic [63:0] typed_vtime);
        logic        gives;
        logic [63:0] vtime;
        if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= IN_TDATA_W'({pon, raw});
        do @(posedge clk); while (!s_tready);
        apply_request(req, raw, pon, gives, vtime);
        if (gives)
        begin
            vtime_due.push_back(typed ? typed_vtime : vtime);
        end
    endtask

    // Lets the pipeline empty out; pause requests leave nothing to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (vtime_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [SPEED_W-1:0] rate);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge clk); while (!cfg_ready);
        rate_q16 = rate;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        logic [63:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (vtime_due.size() == 0)
                begin
                    $display("%0t: unexpected virtual_time transfer: expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = vtime_due.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: virtual_time mismatch: expected %h, got %h",
                                 $time, want, m_tdata);
                        errors++;
                    end
                end
            end
            if (ready_hold != 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0)
            begin
                ready_hold = $urandom_range(17, 0);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_pausable_scaled_time_base_core failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [SPEED_W-1:0] rate;
        logic [63:0]        raw;
        logic [63:0]        tick;
        logic               req;
        logic               pon;
        int unsigned        pick;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_QUERY;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        rate_q16   = SPEED_ONE;
        last_raw   = '0;
        run_time   = '0;
        pause_mark = '0;
        pause_sum  = '0;
        held       = 1'b0;

        plan = '{
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd0,                 32'd0, 1'b1, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd100,               32'd0, 1'b1, 64'd100},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd40,                32'd0, 1'b1, 64'd40},
            '{ROW_ITEM, REQ_PAUSE, 1'b1, 64'hDEAD_BEEF_0123_4567, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_PAUSE, 1'b1, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd5000,              32'd0, 1'b1, 64'd40},
            '{ROW_ITEM, REQ_PAUSE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_PAUSE, 1'b0, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd5010,              32'd0, 1'b1, 64'd50},
            '{ROW_ITEM, REQ_QUERY, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'h8000_0000_0000_0000, 32'd0, 1'b0, 64'd0},
            '{ROW_RATE, REQ_QUERY, 1'b0, 64'd0,                 32'h0000_0000, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd1,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_RATE, REQ_QUERY, 1'b0, 64'd0,                 32'hFFFF_FFFF, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_RATE, REQ_QUERY, 1'b0, 64'd0,                 32'h0000_8000, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd1,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd3,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_PAUSE, 1'b1, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b1, 64'd100,               32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_PAUSE, 1'b0, 64'd0,                 32'd0, 1'b0, 64'd0},
            '{ROW_RATE, REQ_QUERY, 1'b0, 64'd0,                 32'h0002_0000, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd10,                32'd0, 1'b0, 64'd0},
            '{ROW_ITEM, REQ_QUERY, 1'b0, 64'd4,                 32'd0, 1'b0, 64'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idle_odds = 5;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_RATE)
            begin
                write_rate(plan[i].rate);
            end
            else
            begin
                send_request(plan[i].req, plan[i].raw, plan[i].pon,
                             plan[i].typed, plan[i].vtime);
            end
        end

        tick = {$urandom, $urandom};
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: rate = SPEED_ONE;
                1: rate = '0;
                2: rate = '1;
                3: rate = SPEED_ONE - 1;
                4: rate = SPEED_ONE + 1;
                default: rate = $urandom_range(1, 0) ? $urandom : $urandom_range(32'h4_0000, 0);
            endcase
            // One phase runs without stalls mid-run; the last one has none either.
            idle_odds = (ph == 2 || ph == RAND_PHASES - 1) ? 0 : $urandom_range(8, 3);
            write_rate(rate);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99, 0);
                pon  = 1'($urandom_range(1, 0));
                req  = REQ_QUERY;
                if (pick < 14)
                begin
                    req = REQ_PAUSE;
                    raw = {$urandom, $urandom};
                end
                else if (pick < 80)
                begin
                    tick = tick + $urandom_range(4000, 0);
                    raw  = tick;
                end
                else if (pick < 90)
                begin
                    raw = tick - $urandom_range(4000, 0);
                end
                else
                begin
                    raw  = {$urandom, $urandom};
                    tick = raw;
                end
                send_request(req, raw, pon, 1'b0, 64'd0);
            end
        end

        settle();
        if (errors == 0)
        begin
            $display("tb_pausable_scaled_time_base_core passed");
        end
        else
        begin
            $display("tb_pausable_scaled_time_base_core failed");
        end
        $finish;
    end

endmodule
